// File: src/jtfk_pkg.sv
package jtfk_pkg;

   localparam int MAX_JOINTS = 32;
   localparam int IDX_W      = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int ACC_W      = 56;
   localparam int OPB_W      = 36;
   localparam int NUM_STEPS  = 35;
   localparam int STEP_W     = $clog2(NUM_STEPS);

   localparam logic signed [15:0] Q_ONE = 16'sd16384;

   typedef enum logic {
      ACT_ROOT  = 1'b0,
      ACT_JOINT = 1'b1
   } action_type;

   typedef struct packed {
      logic               action;
      logic [4:0]         joint_index;
      logic [4:0]         parent_index;
      logic               has_parent;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } req_word_type;

   typedef struct packed {
      logic [4:0]         out_joint;
      logic signed [15:0] abs_w;
      logic signed [15:0] abs_x;
      logic signed [15:0] abs_y;
      logic signed [15:0] abs_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               saturated;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_COMMIT
   } state_type;

   typedef enum logic [3:0] {
      SA_P0, SA_P1, SA_P2, SA_P3,
      SA_A0, SA_A1, SA_A2, SA_A3,
      SA_ONE
   } asel_type;

   typedef enum logic [3:0] {
      SB_Q0, SB_Q1, SB_Q2, SB_Q3,
      SB_V0, SB_V1, SB_V2,
      SB_U0, SB_U1, SB_U2
   } bsel_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_A0, WB_A1, WB_A2, WB_A3,
      WB_U0, WB_U1, WB_U2,
      WB_P0, WB_P1, WB_P2
   } wb_type;

   // wb stores the accumulator as it stands before this step updates it
   typedef struct packed {
      logic     mac;
      logic     first;
      logic     neg;
      logic     dbl;
      asel_type a_sel;
      bsel_type b_sel;
      wb_type   wb;
   } uop_type;

   typedef struct packed {
      logic              accept;
      logic              load;
      logic              step_en;
      logic [STEP_W-1:0] step;
      logic              commit;
   } cmd_type;

   typedef struct packed {
      logic start_joint;
      logic rsp_valid;
      logic rsp_ready;
   } sts_type;

   function automatic uop_type mk(asel_type a, bsel_type b, logic neg, logic dbl,
                                  logic first, wb_type wb);
      uop_type u;
      u.mac   = 1'b1;
      u.first = first;
      u.neg   = neg;
      u.dbl   = dbl;
      u.a_sel = a;
      u.b_sel = b;
      u.wb    = wb;
      return u;
   endfunction

   // Quaternion product, then u = a x v, then r = v*2^14 + 2*(a x u + w*u)
   function automatic uop_type uop_at(logic [STEP_W-1:0] s);
      uop_type u;
      u = '{mac: 1'b0, first: 1'b0, neg: 1'b0, dbl: 1'b0,
            a_sel: SA_ONE, b_sel: SB_Q0, wb: WB_NONE};
      case (s)
         STEP_W'(0):  u = mk(SA_P0, SB_Q0, 1'b0, 1'b0, 1'b1, WB_NONE);
         STEP_W'(1):  u = mk(SA_P1, SB_Q1, 1'b1, 1'b0, 1'b0, WB_NONE);
         STEP_W'(2):  u = mk(SA_P2, SB_Q2, 1'b1, 1'b0, 1'b0, WB_NONE);
         STEP_W'(3):  u = mk(SA_P3, SB_Q3, 1'b1, 1'b0, 1'b0, WB_NONE);
         STEP_W'(4):  u = mk(SA_P0, SB_Q1, 1'b0, 1'b0, 1'b1, WB_A0);
         STEP_W'(5):  u = mk(SA_P1, SB_Q0, 1'b0, 1'b0, 1'b0, WB_NONE);
         STEP_W'(6):  u = mk(SA_P2, SB_Q3, 1'b0, 1'b0, 1'b0, WB_NONE);
         STEP_W'(7):  u = mk(SA_P3, SB_Q2, 1'b1, 1'b0, 1'b0, WB_NONE);
         STEP_W'(8):  u = mk(SA_P0, SB_Q2, 1'b0, 1'b0, 1'b1, WB_A1);
         STEP_W'(9):  u = mk(SA_P2, SB_Q0, 1'b0, 1'b0, 1'b0, WB_NONE);
         STEP_W'(10): u = mk(SA_P3, SB_Q1, 1'b0, 1'b0, 1'b0, WB_NONE);
         STEP_W'(11): u = mk(SA_P1, SB_Q3, 1'b1, 1'b0, 1'b0, WB_NONE);
         STEP_W'(12): u = mk(SA_P0, SB_Q3, 1'b0, 1'b0, 1'b1, WB_A2);
         STEP_W'(13): u = mk(SA_P3, SB_Q0, 1'b0, 1'b0, 1'b0, WB_NONE);
         STEP_W'(14): u = mk(SA_P1, SB_Q2, 1'b0, 1'b0, 1'b0, WB_NONE);
         STEP_W'(15): u = mk(SA_P2, SB_Q1, 1'b1, 1'b0, 1'b0, WB_NONE);
         STEP_W'(16): u = mk(SA_A2, SB_V2, 1'b0, 1'b0, 1'b1, WB_A3);
         STEP_W'(17): u = mk(SA_A3, SB_V1, 1'b1, 1'b0, 1'b0, WB_NONE);
         STEP_W'(18): u = mk(SA_A3, SB_V0, 1'b0, 1'b0, 1'b1, WB_U0);
         STEP_W'(19): u = mk(SA_A1, SB_V2, 1'b1, 1'b0, 1'b0, WB_NONE);
         STEP_W'(20): u = mk(SA_A1, SB_V1, 1'b0, 1'b0, 1'b1, WB_U1);
         STEP_W'(21): u = mk(SA_A2, SB_V0, 1'b1, 1'b0, 1'b0, WB_NONE);
         STEP_W'(22): u = mk(SA_ONE, SB_V0, 1'b0, 1'b0, 1'b1, WB_U2);
         STEP_W'(23): u = mk(SA_A2, SB_U2, 1'b0, 1'b1, 1'b0, WB_NONE);
         STEP_W'(24): u = mk(SA_A3, SB_U1, 1'b1, 1'b1, 1'b0, WB_NONE);
         STEP_W'(25): u = mk(SA_A0, SB_U0, 1'b0, 1'b1, 1'b0, WB_NONE);
         STEP_W'(26): u = mk(SA_ONE, SB_V1, 1'b0, 1'b0, 1'b1, WB_P0);
         STEP_W'(27): u = mk(SA_A3, SB_U0, 1'b0, 1'b1, 1'b0, WB_NONE);
         STEP_W'(28): u = mk(SA_A1, SB_U2, 1'b1, 1'b1, 1'b0, WB_NONE);
         STEP_W'(29): u = mk(SA_A0, SB_U1, 1'b0, 1'b1, 1'b0, WB_NONE);
         STEP_W'(30): u = mk(SA_ONE, SB_V2, 1'b0, 1'b0, 1'b1, WB_P1);
         STEP_W'(31): u = mk(SA_A1, SB_U1, 1'b0, 1'b1, 1'b0, WB_NONE);
         STEP_W'(32): u = mk(SA_A2, SB_U0, 1'b1, 1'b1, 1'b0, WB_NONE);
         STEP_W'(33): u = mk(SA_A0, SB_U2, 1'b0, 1'b1, 1'b0, WB_NONE);
         STEP_W'(34): u.wb = WB_P2;
         default:     u.wb = WB_NONE;
      endcase
      return u;
   endfunction

endpackage

// File: src/jtfk_if.sv
interface jtfk_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [4:0]         joint_index;
   logic [4:0]         parent_index;
   logic               has_parent;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [31:0] vec_x;
   logic signed [31:0] vec_y;
   logic signed [31:0] vec_z;

   modport source(output valid, action, joint_index, parent_index, has_parent,
                  quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  input ready);
   modport sink(input valid, action, joint_index, parent_index, has_parent,
                quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                output ready);
endinterface

interface jtfk_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         out_joint;
   logic signed [15:0] abs_w;
   logic signed [15:0] abs_x;
   logic signed [15:0] abs_y;
   logic signed [15:0] abs_z;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic               saturated;

   modport source(output valid, out_joint, abs_w, abs_x, abs_y, abs_z,
                  pos_x, pos_y, pos_z, saturated, input ready);
   modport sink(input valid, out_joint, abs_w, abs_x, abs_y, abs_z,
                pos_x, pos_y, pos_z, saturated, output ready);
endinterface

// File: src/jtfk_ctrl.sv
module jtfk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jtfk_pkg::sts_type sts,
   output jtfk_pkg::cmd_type cmd
);
   import jtfk_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_free;

   assign out_free = !sts.rsp_valid || sts.rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid && sts.start_joint) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_RUN;
         ST_RUN:    if (step_ff == STEP_W'(NUM_STEPS - 1)) state_in = ST_COMMIT;
         ST_COMMIT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.step    = step_ff;
      step_in     = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
         end
         ST_RUN: begin
            cmd.step_en = 1'b1;
            step_in     = step_ff + 1'b1;
         end
         ST_COMMIT: cmd.commit = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!sts.rsp_valid || sts.rsp_ready))
      else $error("result word overwritten while still pending");
   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE && req_ready))
      else $error("controller did not return to idle after commit");
   a_run_from_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cmd.step_en && step_ff == '0))
      else $error("microcode did not start at step zero");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step_en |-> (step_ff < STEP_W'(NUM_STEPS)))
      else $error("microcode step out of range");
endmodule

// File: src/jtfk_dp.sv
module jtfk_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  jtfk_pkg::req_word_type req_word,
   input  logic                   rsp_ready,
   input  jtfk_pkg::cmd_type      cmd,
   output jtfk_pkg::sts_type      sts,
   output jtfk_pkg::rsp_word_type rsp_word,
   output logic                   rsp_valid
);
   import jtfk_pkg::*;

   logic [63:0] abs_mem [MAX_JOINTS];
   logic [95:0] pos_mem [MAX_JOINTS];

   logic signed [15:0] q_ff [4];
   logic signed [31:0] v_ff [3];
   logic [4:0]         joint_ff;
   logic [IDX_W-1:0]   jaddr_ff;
   logic               hp_ff;
   logic signed [15:0] root_q_ff [4];
   logic signed [31:0] root_v_ff [3];
   logic [63:0]        rd_abs_ff;
   logic [95:0]        rd_pos_ff;
   logic signed [15:0] p_ff [4];
   logic signed [31:0] base_ff [3];
   logic signed [15:0] a_ff [4];
   logic signed [OPB_W-1:0] u_ff [3];
   logic signed [31:0] pos_ff [3];
   logic signed [ACC_W-1:0] acc_ff;
   logic               sat_ff;
   rsp_word_type       rsp_ff;
   logic               rsp_valid_ff;

   uop_type                 op;
   logic signed [15:0]      opa;
   logic signed [OPB_W-1:0] opb;
   logic signed [51:0]      prod;
   logic signed [ACC_W-1:0] term;
   logic signed [ACC_W-1:0] rnd_full;
   logic signed [41:0]      rnd;
   logic signed [15:0]      a_clamped;
   logic                    a_sat;
   logic signed [42:0]      psum;
   logic signed [31:0]      p_clamped;
   logic                    p_sat;
   logic signed [31:0]      wb_base;
   logic                    range_ok;

   assign range_ok = (32'(req_word.joint_index) < MAX_JOINTS) &&
                     (!req_word.has_parent || (32'(req_word.parent_index) < MAX_JOINTS));
   assign sts.start_joint = (req_word.action == ACT_JOINT) && range_ok;
   assign sts.rsp_valid   = rsp_valid_ff;
   assign sts.rsp_ready   = rsp_ready;

   assign op = uop_at(cmd.step);

   always_comb begin
      case (op.a_sel)
         SA_P0:   opa = p_ff[0];
         SA_P1:   opa = p_ff[1];
         SA_P2:   opa = p_ff[2];
         SA_P3:   opa = p_ff[3];
         SA_A0:   opa = a_ff[0];
         SA_A1:   opa = a_ff[1];
         SA_A2:   opa = a_ff[2];
         SA_A3:   opa = a_ff[3];
         default: opa = Q_ONE;
      endcase
      case (op.b_sel)
         SB_Q0:   opb = OPB_W'(q_ff[0]);
         SB_Q1:   opb = OPB_W'(q_ff[1]);
         SB_Q2:   opb = OPB_W'(q_ff[2]);
         SB_Q3:   opb = OPB_W'(q_ff[3]);
         SB_V0:   opb = OPB_W'(v_ff[0]);
         SB_V1:   opb = OPB_W'(v_ff[1]);
         SB_V2:   opb = OPB_W'(v_ff[2]);
         SB_U0:   opb = u_ff[0];
         SB_U1:   opb = u_ff[1];
         SB_U2:   opb = u_ff[2];
         default: opb = '0;
      endcase
   end

   assign prod = opa * opb;

   always_comb begin
      term = ACC_W'(prod);
      if (op.dbl) term = term <<< 1;
      if (op.neg) term = -term;
   end

   // round half up by 14 bits
   assign rnd_full = (acc_ff + ACC_W'(1 << 13)) >>> 14;
   assign rnd      = rnd_full[41:0];

   always_comb begin
      a_sat = 1'b1;
      if (rnd > 42'sd16384) a_clamped = Q_ONE;
      else if (rnd < -42'sd16384) a_clamped = -Q_ONE;
      else begin
         a_clamped = rnd[15:0];
         a_sat     = 1'b0;
      end
   end

   always_comb begin
      case (op.wb)
         WB_P0:   wb_base = base_ff[0];
         WB_P1:   wb_base = base_ff[1];
         default: wb_base = base_ff[2];
      endcase
      psum  = 43'(wb_base) + 43'(rnd);
      p_sat = 1'b1;
      if (psum > 43'sd2147483647) p_clamped = 32'sh7fffffff;
      else if (psum < -43'sd2147483648) p_clamped = 32'sh80000000;
      else begin
         p_clamped = psum[31:0];
         p_sat     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_abs_ff <= abs_mem[IDX_W'(req_word.parent_index)];
         rd_pos_ff <= pos_mem[IDX_W'(req_word.parent_index)];
      end
      if (cmd.commit) begin
         abs_mem[jaddr_ff] <= {a_ff[0], a_ff[1], a_ff[2], a_ff[3]};
         pos_mem[jaddr_ff] <= {pos_ff[0], pos_ff[1], pos_ff[2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_q_ff[0] <= Q_ONE;
         root_q_ff[1] <= '0;
         root_q_ff[2] <= '0;
         root_q_ff[3] <= '0;
         root_v_ff[0] <= '0;
         root_v_ff[1] <= '0;
         root_v_ff[2] <= '0;
      end else if (cmd.accept && req_word.action == ACT_ROOT) begin
         root_q_ff[0] <= req_word.quat_w;
         root_q_ff[1] <= req_word.quat_x;
         root_q_ff[2] <= req_word.quat_y;
         root_q_ff[3] <= req_word.quat_z;
         root_v_ff[0] <= req_word.vec_x;
         root_v_ff[1] <= req_word.vec_y;
         root_v_ff[2] <= req_word.vec_z;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         q_ff[0]  <= req_word.quat_w;
         q_ff[1]  <= req_word.quat_x;
         q_ff[2]  <= req_word.quat_y;
         q_ff[3]  <= req_word.quat_z;
         v_ff[0]  <= req_word.vec_x;
         v_ff[1]  <= req_word.vec_y;
         v_ff[2]  <= req_word.vec_z;
         joint_ff <= req_word.joint_index;
         jaddr_ff <= IDX_W'(req_word.joint_index);
         hp_ff    <= req_word.has_parent;
      end
      if (cmd.load) begin
         p_ff[0]    <= hp_ff ? rd_abs_ff[63:48] : root_q_ff[0];
         p_ff[1]    <= hp_ff ? rd_abs_ff[47:32] : root_q_ff[1];
         p_ff[2]    <= hp_ff ? rd_abs_ff[31:16] : root_q_ff[2];
         p_ff[3]    <= hp_ff ? rd_abs_ff[15:0]  : root_q_ff[3];
         base_ff[0] <= hp_ff ? rd_pos_ff[95:64] : root_v_ff[0];
         base_ff[1] <= hp_ff ? rd_pos_ff[63:32] : root_v_ff[1];
         base_ff[2] <= hp_ff ? rd_pos_ff[31:0]  : root_v_ff[2];
         sat_ff     <= 1'b0;
      end
      if (cmd.step_en) begin
         if (op.mac) acc_ff <= op.first ? term : acc_ff + term;
         case (op.wb)
            WB_A0: begin a_ff[0] <= a_clamped; sat_ff <= sat_ff | a_sat; end
            WB_A1: begin a_ff[1] <= a_clamped; sat_ff <= sat_ff | a_sat; end
            WB_A2: begin a_ff[2] <= a_clamped; sat_ff <= sat_ff | a_sat; end
            WB_A3: begin a_ff[3] <= a_clamped; sat_ff <= sat_ff | a_sat; end
            WB_U0: u_ff[0] <= rnd[OPB_W-1:0];
            WB_U1: u_ff[1] <= rnd[OPB_W-1:0];
            WB_U2: u_ff[2] <= rnd[OPB_W-1:0];
            WB_P0: begin pos_ff[0] <= p_clamped; sat_ff <= sat_ff | p_sat; end
            WB_P1: begin pos_ff[1] <= p_clamped; sat_ff <= sat_ff | p_sat; end
            WB_P2: begin pos_ff[2] <= p_clamped; sat_ff <= sat_ff | p_sat; end
            default: ;
         endcase
      end
      if (cmd.commit) begin
         rsp_ff.out_joint <= joint_ff;
         rsp_ff.abs_w     <= a_ff[0];
         rsp_ff.abs_x     <= a_ff[1];
         rsp_ff.abs_y     <= a_ff[2];
         rsp_ff.abs_z     <= a_ff[3];
         rsp_ff.pos_x     <= pos_ff[0];
         rsp_ff.pos_y     <= pos_ff[1];
         rsp_ff.pos_z     <= pos_ff[2];
         rsp_ff.saturated <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.commit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_word  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   a_commit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed word not presented");
   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && !cmd.commit) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending result word changed");
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.load, cmd.step_en, cmd.commit}))
      else $error("conflicting datapath commands");
endmodule

// File: src/joint_tree_forward_kinematics.sv
// Forward kinematics over a joint tree, fixed point.
// req_chan takes words with valid/ready. A word with action 0 sets the root
// orientation (Q1.14) and root position (Q16.16) and produces nothing. A word
// with action 1 processes one joint: the parent's stored pose (or the root
// pose) is combined with the local rotation and bind offset, the result is
// stored under joint_index and sent on rsp_chan.
// Joint words whose indexes are out of range are dropped silently.
// Parents must be sent before their children.
// A joint word runs through one shared 16x36 multiply-accumulate unit under
// a 35-step microcode sequence, and a new word is taken only after the
// previous joint has committed and the controller has returned to idle.
// rsp_chan is a registered output: if the receiver stalls, the next joint
// is still computed and waits for the output register before it commits.
// Reset restores the identity root orientation and zero root position; pose
// memories are not cleared: the user must write each pose before use (unchecked).
module joint_tree_forward_kinematics (
   input  logic        clock,
   input  logic        reset,
   jtfk_req_if.sink    req_chan,
   jtfk_rsp_if.source  rsp_chan
);
   import jtfk_pkg::*;

   req_word_type req_word;
   rsp_word_type rsp_word;
   cmd_type      cmd;
   sts_type      sts;

   assign req_word.action       = req_chan.action;
   assign req_word.joint_index  = req_chan.joint_index;
   assign req_word.parent_index = req_chan.parent_index;
   assign req_word.has_parent   = req_chan.has_parent;
   assign req_word.quat_w       = req_chan.quat_w;
   assign req_word.quat_x       = req_chan.quat_x;
   assign req_word.quat_y       = req_chan.quat_y;
   assign req_word.quat_z       = req_chan.quat_z;
   assign req_word.vec_x        = req_chan.vec_x;
   assign req_word.vec_y        = req_chan.vec_y;
   assign req_word.vec_z        = req_chan.vec_z;

   jtfk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   jtfk_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_chan.valid)
   );

   assign rsp_chan.out_joint = rsp_word.out_joint;
   assign rsp_chan.abs_w     = rsp_word.abs_w;
   assign rsp_chan.abs_x     = rsp_word.abs_x;
   assign rsp_chan.abs_y     = rsp_word.abs_y;
   assign rsp_chan.abs_z     = rsp_word.abs_z;
   assign rsp_chan.pos_x     = rsp_word.pos_x;
   assign rsp_chan.pos_y     = rsp_word.pos_y;
   assign rsp_chan.pos_z     = rsp_word.pos_z;
   assign rsp_chan.saturated = rsp_word.saturated;
endmodule
